FILE: hw/rtl/jacobi_linear_solver_core_macros.svh
// Assertion macros shared by the Jacobi solver RTL.
`ifndef JACOBI_LINEAR_SOLVER_CORE_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jls assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jls assertion failed");

`endif

FILE: hw/rtl/jls_pkg.sv
// Types, constants and arithmetic helpers of the Jacobi solver.
`default_nettype none

package jls_pkg;

  localparam int MSIZE = 16;
  localparam int IDX_W = $clog2(MSIZE);
  localparam int AW    = $clog2(MSIZE * MSIZE);
  localparam int ACC_W = 38;

  // input modes
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_SOLVE  = 2'd2;

  // queued command codes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [31:0] solution;
    logic               converged;
    logic [7:0]         sweeps_used;
    logic               zero_pivot;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [31:0] value;
  } cmd_t;

  // Q16.16 product: floor shift by 16, saturate to 32 bits
  function automatic logic signed [31:0] sat_shift16(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (s < -48'sd2147483648) return 32'sh8000_0000;
    else                           return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] a);
    if (a > ACC_W'(64'sd2147483647))       return 32'sh7FFF_FFFF;
    else if (a < -ACC_W'(64'sd2147483648)) return 32'sh8000_0000;
    else                                   return a[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jls_front.sv
// Front end: accepts input transfers, drops dead ones, queues commands.
`default_nettype none

module jls_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jls_pkg::in_item_t in_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output jls_pkg::cmd_t          q_data,
  output logic                   q_valid,
  input  wire logic              q_pop
);
  import jls_pkg::*;

  logic       row_ok, col_ok, keep, push;
  cmd_t       cmd;
  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign row_ok = {1'b0, in_data.row} < 7'(MSIZE);
  assign col_ok = {1'b0, in_data.col} < 7'(MSIZE);

  always_comb begin
    cmd.row   = in_data.row[IDX_W-1:0];
    cmd.col   = in_data.col[IDX_W-1:0];
    cmd.value = in_data.value;
    unique case (in_data.mode)
      MODE_LOAD_A: begin cmd.op = OP_LOAD_A; keep = row_ok && col_ok; end
      MODE_LOAD_B: begin cmd.op = OP_LOAD_B; keep = row_ok; end
      MODE_SOLVE:  begin cmd.op = OP_SOLVE;  keep = 1'b1; end
      default:     begin cmd.op = OP_SOLVE;  keep = 1'b0; end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cmd;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jls_back.sv
// Back end: matrix store, pivot divider, sweep and residual sequencer.
`default_nettype none

`include "jacobi_linear_solver_core_macros.svh"

module jls_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jls_pkg::cmd_t      q_data,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic [7:0]         max_iter,
  input  wire logic [30:0]        res_limit,
  output jls_pkg::res_item_t      out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import jls_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DG_RD   = 5'd1;
  localparam logic [4:0] S_DG_CHK  = 5'd2;
  localparam logic [4:0] S_DIV     = 5'd3;
  localparam logic [4:0] S_DG_FIN  = 5'd4;
  localparam logic [4:0] S_LIM     = 5'd5;
  localparam logic [4:0] S_LIM2    = 5'd6;
  localparam logic [4:0] S_SW_INIT = 5'd7;
  localparam logic [4:0] S_SW_RD   = 5'd8;
  localparam logic [4:0] S_SW_MUL  = 5'd9;
  localparam logic [4:0] S_SW_ACC  = 5'd10;
  localparam logic [4:0] S_SW_ROW  = 5'd11;
  localparam logic [4:0] S_SW_ROW2 = 5'd12;
  localparam logic [4:0] S_SW_COPY = 5'd13;
  localparam logic [4:0] S_RS_INIT = 5'd14;
  localparam logic [4:0] S_RS_RD   = 5'd15;
  localparam logic [4:0] S_RS_MUL  = 5'd16;
  localparam logic [4:0] S_RS_ACC  = 5'd17;
  localparam logic [4:0] S_RS_SQ   = 5'd18;
  localparam logic [4:0] S_RS_NORM = 5'd19;
  localparam logic [4:0] S_CHK     = 5'd20;
  localparam logic [4:0] S_OUT     = 5'd21;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSIZE - 1);

  logic [4:0]               state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_item_t                out_data_r;

  logic signed [31:0]       mat_mem [MSIZE*MSIZE];
  logic signed [31:0]       mem_q_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;

  logic signed [31:0]       rhs_r  [MSIZE];
  logic signed [31:0]       inv_r  [MSIZE];
  logic signed [31:0]       prev_r [MSIZE];
  logic signed [31:0]       next_r [MSIZE];

  logic [IDX_W-1:0]         i_r, j_r;
  logic                     i_last, j_last;
  logic                     pz_r, conv_r, neg_r;
  logic [7:0]               sweep_r, budget_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [31:0]       acc_sat;
  logic signed [63:0]       prod_r;
  logic signed [31:0]       mul_a, mul_b;
  logic [63:0]              norm_r, limsq_r;
  logic [64:0]              norm_sum;

  // restoring divider for 2^32 / |A_ii|
  logic [32:0]              div_r, rem_r, dq_r, rem_sh, neg_q;
  logic [5:0]               cnt_r;
  logic                     div_ge;
  logic signed [32:0]       d_ext;
  logic signed [31:0]       div_res;
  logic                     load_out;

  assign i_last  = (i_r == LAST_IDX);
  assign j_last  = (j_r == LAST_IDX);
  assign acc_sat = sat_acc(acc_r);

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // matrix store, one write and one registered read per cycle
  assign mem_we    = q_pop && (q_data.op == OP_LOAD_A);
  assign mem_waddr = AW'(AW'(q_data.row) * AW'(MSIZE) + AW'(q_data.col));
  assign mem_raddr = (state_r == S_DG_RD) ? AW'(AW'(i_r) * AW'(MSIZE) + AW'(i_r))
                                          : AW'(AW'(i_r) * AW'(MSIZE) + AW'(j_r));

  always_ff @(posedge clk) begin
    if (mem_we) mat_mem[mem_waddr] <= q_data.value;
    mem_q_r <= mat_mem[mem_raddr];
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_SW_ROW: begin mul_a = acc_sat; mul_b = inv_r[i_r]; end
      S_RS_SQ:  begin mul_a = acc_sat; mul_b = acc_sat; end
      S_LIM:    begin mul_a = {1'b0, res_limit}; mul_b = {1'b0, res_limit}; end
      default:  begin mul_a = mem_q_r; mul_b = prev_r[j_r]; end
    endcase
  end

  assign d_ext  = {mem_q_r[31], mem_q_r};
  assign rem_sh = {rem_r[31:0], dq_r[32]};
  assign div_ge = (rem_sh >= div_r);
  assign neg_q  = ~dq_r + 33'd1;

  always_comb begin
    if (!neg_r) div_res = (dq_r > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_r[31:0];
    else        div_res = (dq_r > 33'h0_8000_0000) ? 32'sh8000_0000 : neg_q[31:0];
  end

  assign norm_sum = {1'b0, norm_r} + {1'b0, prod_r[63:0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (q_valid && (q_data.op == OP_SOLVE)) state_nxt = S_DG_RD;
      S_DG_RD:   state_nxt = S_DG_CHK;
      S_DG_CHK:  if (mem_q_r != 32'sd0) state_nxt = S_DIV;
                 else state_nxt = i_last ? S_LIM : S_DG_RD;
      S_DIV:     if (cnt_r == 6'd1) state_nxt = S_DG_FIN;
      S_DG_FIN:  state_nxt = i_last ? S_LIM : S_DG_RD;
      S_LIM:     state_nxt = pz_r ? S_OUT : S_LIM2;
      S_LIM2:    state_nxt = S_SW_INIT;
      S_SW_INIT: state_nxt = S_SW_RD;
      S_SW_RD:   if (j_r != i_r) state_nxt = S_SW_MUL;
                 else if (j_last) state_nxt = S_SW_ROW;
      S_SW_MUL:  state_nxt = S_SW_ACC;
      S_SW_ACC:  state_nxt = j_last ? S_SW_ROW : S_SW_RD;
      S_SW_ROW:  state_nxt = S_SW_ROW2;
      S_SW_ROW2: state_nxt = i_last ? S_SW_COPY : S_SW_INIT;
      S_SW_COPY: state_nxt = S_RS_INIT;
      S_RS_INIT: state_nxt = S_RS_RD;
      S_RS_RD:   state_nxt = S_RS_MUL;
      S_RS_MUL:  state_nxt = S_RS_ACC;
      S_RS_ACC:  state_nxt = j_last ? S_RS_SQ : S_RS_RD;
      S_RS_SQ:   state_nxt = S_RS_NORM;
      S_RS_NORM: state_nxt = i_last ? S_CHK : S_RS_INIT;
      S_CHK:     if ((norm_r < limsq_r) || (sweep_r == budget_r)) state_nxt = S_OUT;
                 else state_nxt = S_SW_INIT;
      S_OUT:     if (load_out && j_last) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && (q_data.op == OP_LOAD_B)) rhs_r[q_data.row] <= q_data.value;
        if (q_pop && (q_data.op == OP_SOLVE)) begin
          i_r     <= '0;
          pz_r    <= 1'b0;
          conv_r  <= 1'b0;
          sweep_r <= 8'd0;
        end
      end
      S_DG_CHK: begin
        if (mem_q_r == 32'sd0) begin
          pz_r       <= 1'b1;
          inv_r[i_r] <= 32'sd0;
          i_r        <= i_last ? '0 : i_r + 1'b1;
        end else begin
          neg_r <= mem_q_r[31];
          div_r <= mem_q_r[31] ? -d_ext : d_ext;
          rem_r <= 33'd0;
          dq_r  <= {1'b1, 32'd0};
          cnt_r <= 6'd33;
        end
      end
      S_DIV: begin
        rem_r <= div_ge ? (rem_sh - div_r) : rem_sh;
        dq_r  <= {dq_r[31:0], div_ge};
        cnt_r <= cnt_r - 6'd1;
      end
      S_DG_FIN: begin
        inv_r[i_r] <= div_res;
        i_r        <= i_last ? '0 : i_r + 1'b1;
      end
      S_LIM: begin
        for (int k = 0; k < MSIZE; k++) prev_r[k] <= 32'sd0;
        budget_r <= (max_iter == 8'd0) ? 8'd1 : max_iter;
        j_r      <= '0;
      end
      S_LIM2:    limsq_r <= prod_r[63:0];
      S_SW_INIT: begin
        acc_r <= ext_acc(rhs_r[i_r]);
        j_r   <= '0;
      end
      S_SW_RD:   if ((j_r == i_r) && !j_last) j_r <= j_r + 1'b1;
      S_SW_ACC: begin
        acc_r <= acc_r - ext_acc(sat_shift16(prod_r));
        if (!j_last) j_r <= j_r + 1'b1;
      end
      S_SW_ROW2: begin
        next_r[i_r] <= sat_shift16(prod_r);
        i_r         <= i_last ? '0 : i_r + 1'b1;
      end
      S_SW_COPY: begin
        for (int k = 0; k < MSIZE; k++) prev_r[k] <= next_r[k];
        sweep_r <= sweep_r + 8'd1;
        norm_r  <= 64'd0;
      end
      S_RS_INIT: begin
        acc_r <= -ext_acc(rhs_r[i_r]);
        j_r   <= '0;
      end
      S_RS_ACC: begin
        acc_r <= acc_r + ext_acc(sat_shift16(prod_r));
        if (!j_last) j_r <= j_r + 1'b1;
      end
      S_RS_NORM: begin
        norm_r <= norm_sum[64] ? '1 : norm_sum[63:0];
        i_r    <= i_last ? '0 : i_r + 1'b1;
      end
      S_CHK: begin
        if (norm_r < limsq_r) conv_r <= 1'b1;
        j_r <= '0;
      end
      S_OUT: begin
        if (load_out) begin
          out_data_r.index       <= 6'(j_r);
          out_data_r.solution    <= prev_r[j_r];
          out_data_r.converged   <= conv_r;
          out_data_r.sweeps_used <= sweep_r;
          out_data_r.zero_pivot  <= pz_r;
          out_data_r.last        <= j_last;
          j_r <= j_last ? '0 : j_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

  `JLS_ASSERT_NOW(a_pop_only_idle, q_pop, state_r == S_IDLE)
  `JLS_ASSERT_NOW(a_idle_holds_last, (state_r == S_IDLE) && out_valid_r, out_data_r.last)
  `JLS_ASSERT_NOW(a_chk_in_budget, state_r == S_CHK, (sweep_r != 8'd0) && (sweep_r <= budget_r))
  `JLS_ASSERT_NEXT(a_div_done, (state_r == S_DIV) && (cnt_r == 6'd1), state_r == S_DG_FIN)

endmodule

`default_nettype wire

FILE: hw/rtl/jacobi_linear_solver_core.sv
// Top level of the Jacobi iterative solver: config registers, front and back.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    jls_pkg::in_item_t
//   out_     output     out_valid / out_ready  jls_pkg::res_item_t
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// Loads enter while the two-entry command queue has room, so they can queue
// while the back end is busy, and mode 3 or out-of-range loads are dropped.
// A solve first forms the pivot inverses with a 33-step divider, then runs
// sweeps: one shared 32x32 multiplier, one matrix read per cycle, a read, a
// multiply and an accumulate state per matrix element, two passes per sweep.
// The 16 results leave through a registered output stage; out_ready low only
// stalls the emit phase. rst_n is synchronous and clears control state only.
`default_nettype none

module jacobi_linear_solver_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire jls_pkg::in_item_t                   in_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  output jls_pkg::res_item_t                       out_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  input  wire logic                                cfg_we,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [jls_pkg::CFG_W-1:0]           cfg_wdata
);
  import jls_pkg::*;

  logic [7:0]  max_iter_r;
  logic [30:0] res_limit_r;
  cmd_t        q_data;
  logic        q_valid, q_pop;

  // config writes are expected only while the core is idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= 8'd50;
      res_limit_r <= 31'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[7:0];
        CFG_RES_LIMIT: res_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accepts transfers while its queue has room, queues the ones that do work
  jls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  // back: stores, divider, sweep sequencer and output register
  jls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .max_iter  (max_iter_r),
    .res_limit (res_limit_r),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire
